// ----- rtl/tsra_pkg.sv -----
// Package for the thermocouple spike-rejecting averager.
// It holds field widths, register indexes and reset constants.
// It has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tsra_pkg;

	localparam int RING_DEPTH = 4;
	localparam int IDX_W      = $clog2(RING_DEPTH);

	localparam int RAW_W      = 12;
	localparam int CFG_W      = 10;
	localparam int SAMPLE_W   = 14;
	localparam int AVG_W      = 17;
	localparam int CMP_W      = 19;
	localparam int COUNT_W    = 8;

	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 56;
	localparam int OUT_TUSER_W = 2;

	typedef enum logic [1:0] {
		REG_BEAN_OFFSET     = 2'd0,
		REG_ENV_OFFSET      = 2'd1,
		REG_SPIKE_THRESHOLD = 2'd2
	} reg_index_t;

	localparam logic [CFG_W-1:0]   THRESH_RESET = CFG_W'(20);
	localparam logic [COUNT_W-1:0] DROP_MAX     = '1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [AVG_W-1:0]    average_t;
	typedef logic signed [CMP_W-1:0]    compare_t;

endpackage

`default_nettype wire

// ----- rtl/thermocouple_spike_reject_averager_top.sv -----
// Top level of the thermocouple spike-rejecting averager.
// Depends on tsra_pkg for widths, register indexes and reset constants.
//
// Usage:
// Each beat on the slave side (s_axis) carries one sample tick: a raw bean
// reading and a raw environment reading. Each accepted beat gives exactly one
// beat on the master side (m_axis) with the corrected bean sample, the
// weighted ring average, the captured environment value, the drop count and
// two flags. The ring state is updated in the cycle of acceptance, so the
// result of a beat appears in the output register on the next cycle:
// throughput is one beat per cycle while m_axis takes each result, set by the
// single output register. A new beat is taken whenever the output register is
// empty or is being emptied in the same cycle, so a stall on the master side
// holds the result and blocks the slave side only for as long as it lasts.
// Reset clears the ring, index, fill flag, average, environment value and
// drop count, sets both offsets to zero and the spike threshold to 20, and
// leaves the output register empty. Configuration writes take effect at the
// clock edge on which cfg_we is high and should be made while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module thermocouple_spike_reject_averager_top (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [1:0]                           cfg_index,
	input  wire logic [tsra_pkg::CFG_W-1:0]           cfg_data,
	input  wire logic                                 s_axis_tvalid,
	output logic                                      s_axis_tready,
	// bean_raw [11:0], env_raw [23:12]
	input  wire logic [tsra_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	output logic                                      m_axis_tvalid,
	input  wire logic                                 m_axis_tready,
	// bean_now [13:0], bean_average [30:14], env_now [44:31],
	// drop_count [52:45], zero fill [55:53]
	output logic [tsra_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
	// rejected [0], ready_res [1]
	output logic [tsra_pkg::OUT_TUSER_W-1:0]          m_axis_tuser
);

	logic signed [tsra_pkg::CFG_W-1:0]   bean_offset_q;
	logic signed [tsra_pkg::CFG_W-1:0]   env_offset_q;
	logic        [tsra_pkg::CFG_W-1:0]   threshold_q;

	tsra_pkg::sample_t                   ring_q [tsra_pkg::RING_DEPTH];
	logic        [tsra_pkg::IDX_W-1:0]   write_index_q;
	logic                                ring_full_q;
	tsra_pkg::average_t                  average_q;
	tsra_pkg::sample_t                   env_q;
	logic        [tsra_pkg::COUNT_W-1:0] count_q;

	logic                                accept;
	logic        [tsra_pkg::RAW_W-1:0]   bean_raw;
	logic        [tsra_pkg::RAW_W-1:0]   env_raw;
	tsra_pkg::sample_t                   bean_c;
	tsra_pkg::sample_t                   env_c;
	tsra_pkg::average_t                  wsum_c;
	tsra_pkg::compare_t                  lhs_c;
	tsra_pkg::compare_t                  rhs_c;
	logic                                reject_c;
	logic                                wrap_c;

	tsra_pkg::average_t                  average_d;
	tsra_pkg::sample_t                   env_d;
	logic                                ring_full_d;
	logic        [tsra_pkg::COUNT_W-1:0] count_d;

	assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign bean_raw = s_axis_tdata[tsra_pkg::RAW_W-1:0];
	assign env_raw  = s_axis_tdata[2*tsra_pkg::RAW_W-1:tsra_pkg::RAW_W];

	always_comb begin
		bean_c = tsra_pkg::sample_t'({2'b00, bean_raw})
			+ tsra_pkg::sample_t'(bean_offset_q);
		env_c  = tsra_pkg::sample_t'({2'b00, env_raw})
			+ tsra_pkg::sample_t'(env_offset_q);

		wsum_c = tsra_pkg::average_t'(ring_q[0])
			+ tsra_pkg::average_t'(ring_q[1])
			+ (tsra_pkg::average_t'(ring_q[2]) <<< 1)
			+ (tsra_pkg::average_t'(ring_q[3]) <<< 2);

		lhs_c = tsra_pkg::compare_t'(bean_c) <<< 3;
		rhs_c = tsra_pkg::compare_t'(wsum_c)
			+ tsra_pkg::compare_t'({6'b0, threshold_q, 3'b000});

		reject_c = ring_full_q && (lhs_c >= rhs_c);
		wrap_c   = !reject_c && (write_index_q == tsra_pkg::IDX_W'(tsra_pkg::RING_DEPTH - 1));

		average_d   = ring_full_q ? wsum_c : average_q;
		env_d       = wrap_c ? env_c : env_q;
		ring_full_d = ring_full_q || wrap_c;
		if (reject_c) begin
			count_d = (count_q == tsra_pkg::DROP_MAX) ? count_q : count_q + 1'b1;
		end else begin
			count_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bean_offset_q <= '0;
			env_offset_q  <= '0;
			threshold_q   <= tsra_pkg::THRESH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tsra_pkg::REG_BEAN_OFFSET:     bean_offset_q <= cfg_data;
				tsra_pkg::REG_ENV_OFFSET:      env_offset_q  <= cfg_data;
				tsra_pkg::REG_SPIKE_THRESHOLD: threshold_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tsra_pkg::RING_DEPTH; i++) begin
				ring_q[i] <= '0;
			end
			write_index_q <= '0;
			ring_full_q   <= 1'b0;
			average_q     <= '0;
			env_q         <= '0;
			count_q       <= '0;
		end else if (accept) begin
			if (!reject_c) begin
				ring_q[write_index_q] <= bean_c;
				write_index_q         <= write_index_q + 1'b1;
			end
			ring_full_q <= ring_full_d;
			average_q   <= average_d;
			env_q       <= env_d;
			count_q     <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (accept) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_axis_tdata <= {3'b000, count_d, env_d, average_d, bean_c};
			m_axis_tuser <= {ring_full_d, reject_c};
		end
	end

endmodule

`default_nettype wire
